// ===== hdl/lztd_pkg.sv =====
// ----------------------------------------------------------------------------
// lztd_pkg: shared types and constants for the lzss token decoder
// Sequencer states, copy length offset and byte counter width.
// ----------------------------------------------------------------------------
package lztd_pkg;

  // a match copies its length code plus this many bytes
  localparam int unsigned MIN_COPY = 3;

  // width of the emitted byte counter and of the output limit register
  localparam int unsigned LIMIT_W = 24;

  // width of one window byte
  localparam int unsigned BYTE_W = 8;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_COPY,
    ST_END
  } lztd_state_t;

endpackage

// ===== hdl/lztd_ram.sv =====
// ----------------------------------------------------------------------------
// lztd_ram: generic simple dual port ram
// One write port and one read port, read data registered on rd_en.
// ----------------------------------------------------------------------------
module lztd_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/lzss_token_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lzss_token_decoder_unit: lzss token decoder with a history window
// Expands literal and match tokens into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens come in on the in_ channel (valid/ready). A literal gives one byte
//   beat; a match gives length code + 3 byte beats copied from the window; a
//   match at position 0 gives a single end beat with out_byte_valid low and
//   out_stream_done high. Every byte beat but the one that reaches the limit is appended to the window.
//   The cfg_ port sets the output limit; the beat that reaches it carries
//   out_stream_done and out_last_of_run, and later tokens are taken and
//   dropped without any beat. Write cfg_ only while the block is idle.
// Throughput:
//   in_ready is high only while the sequencer is idle, so a new token is taken
//   only after the last one is through. A match issues its first window read
//   when it is accepted, then one read per byte. The single window read port
//   sets one byte per cycle while out_ready lets beats leave.
// Reset and stall:
//   Reset zeroes the window logically (a fill mark tracks written entries, no
//   clearing pass), sets the write pointer to 1 and the limit to all ones.
//   When out_ready is low the pending beat holds and the sequencer waits.
// ----------------------------------------------------------------------------
module lzss_token_decoder_unit
  import lztd_pkg::*;
#(
  parameter int unsigned INDEX_BITS  = 13,
  parameter int unsigned LENGTH_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // token input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_is_literal,
  input  logic [BYTE_W-1:0]      in_literal_byte,
  input  logic [INDEX_BITS-1:0]  in_match_position,
  input  logic [LENGTH_BITS-1:0] in_match_length_code,
  // byte output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_byte_valid,
  output logic                   out_last_of_run,
  output logic                   out_stream_done,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_W-1:0]     cfg_wr_data
);

  localparam int unsigned WIN_DEPTH = 1 << INDEX_BITS;
  localparam int unsigned REM_W     = LENGTH_BITS + 1;

  // sequencer and window state
  lztd_state_t             state_r, state_nxt;
  logic [INDEX_BITS-1:0]   wp_r, wp_nxt;
  logic                    wrap_r, wrap_nxt;
  logic [INDEX_BITS-1:0]   pos_r, pos_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [BYTE_W-1:0]       lit_r, lit_nxt;
  logic                    rd_ok_r, rd_ok_nxt;
  logic                    fwd_hit_r, fwd_hit_nxt;
  logic [BYTE_W-1:0]       fwd_r, fwd_nxt;
  logic [LIMIT_W-1:0]      cnt_r, cnt_nxt;
  logic                    stopped_r, stopped_nxt;
  logic [LIMIT_W-1:0]      limit_r;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]       out_byte_r, out_byte_nxt;
  logic                    out_bv_r, out_bv_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_done_r, out_done_nxt;

  // window ram signals
  logic                    ram_we;
  logic                    ram_re;
  logic [INDEX_BITS-1:0]   ram_raddr;
  logic [BYTE_W-1:0]       ram_rdata;

  // emission helpers
  logic                    slot_free;
  logic [BYTE_W-1:0]       emit_byte;
  logic [LIMIT_W-1:0]      cnt_inc;
  logic                    limit_hit;

  lztd_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (WIN_DEPTH),
    .ADDR_W (INDEX_BITS)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wp_r),
    .wr_data (emit_byte),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // output slot can take a beat this cycle
  assign slot_free = !out_valid_r || out_ready;

  // byte source for the beat being produced
  always_comb begin
    if (state_r == ST_LIT) begin
      emit_byte = lit_r;
    end else if (fwd_hit_r) begin
      emit_byte = fwd_r;
    end else if (rd_ok_r) begin
      emit_byte = ram_rdata;
    end else begin
      emit_byte = '0;
    end
  end

  // limit check after each emitted byte
  assign cnt_inc   = cnt_r + LIMIT_W'(1);
  assign limit_hit = (cnt_inc >= limit_r);

  assign in_ready = (state_r == ST_IDLE);

  // sequencer next state and outputs
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    wrap_nxt      = wrap_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    lit_nxt       = lit_r;
    rd_ok_nxt     = rd_ok_r;
    fwd_hit_nxt   = fwd_hit_r;
    fwd_nxt       = fwd_r;
    cnt_nxt       = cnt_r;
    stopped_nxt   = stopped_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = pos_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !stopped_r) begin
          if (in_is_literal) begin
            lit_nxt   = in_literal_byte;
            state_nxt = ST_LIT;
          end else if (in_match_position == '0) begin
            state_nxt = ST_END;
          end else begin
            // first window read of the copy
            ram_re      = 1'b1;
            ram_raddr   = in_match_position;
            rd_ok_nxt   = wrap_r || (in_match_position < wp_r);
            fwd_hit_nxt = 1'b0;
            pos_nxt     = in_match_position + INDEX_BITS'(1);
            rem_nxt     = REM_W'(in_match_length_code) + REM_W'(MIN_COPY);
            state_nxt   = ST_COPY;
          end
        end
      end

      ST_END: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_bv_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          out_done_nxt  = 1'b1;
          stopped_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_LIT, ST_COPY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = emit_byte;
          out_bv_nxt    = 1'b1;
          cnt_nxt       = cnt_inc;
          if (limit_hit) begin
            // limit byte is not stored and ends decoding
            out_last_nxt = 1'b1;
            out_done_nxt = 1'b1;
            stopped_nxt  = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            out_done_nxt = 1'b0;
            ram_we       = 1'b1;
            wp_nxt       = wp_r + INDEX_BITS'(1);
            if (wp_r == '1) begin
              wrap_nxt = 1'b1;
            end
            if (state_r == ST_LIT || rem_r == REM_W'(1)) begin
              out_last_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              // next window read, forwarded when it hits the byte being stored
              out_last_nxt = 1'b0;
              ram_re       = 1'b1;
              rem_nxt      = rem_r - REM_W'(1);
              pos_nxt      = pos_r + INDEX_BITS'(1);
              fwd_hit_nxt  = (pos_r == wp_r);
              fwd_nxt      = emit_byte;
              rd_ok_nxt    = wrap_r || ((pos_r != '0) && (pos_r < wp_r));
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= INDEX_BITS'(1);
      wrap_r      <= 1'b0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      wrap_r      <= wrap_nxt;
      cnt_r       <= cnt_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '1;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    lit_r      <= lit_nxt;
    rd_ok_r    <= rd_ok_nxt;
    fwd_hit_r  <= fwd_hit_nxt;
    fwd_r      <= fwd_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = out_bv_r;
  assign out_last_of_run = out_last_r;
  assign out_stream_done = out_done_r;

`ifndef NO_ASSERTIONS
  // once stopped and drained, no further beat appears
  a_quiet_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r && !out_valid_r |=> !out_valid_r)
    else $error("beat produced after stream stopped");

  // the write pointer only reaches zero after the window wrapped
  a_wp_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !wrap_r |-> wp_r != '0)
    else $error("write pointer at zero before wrap");

  // a copy in progress always has bytes left
  a_copy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COPY |-> rem_r != '0)
    else $error("copy running with no bytes left");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the lzss token decoder unit
// Feeds literal and match tokens, expands each accepted token in a local
// window model and checks every byte beat in order. Runs directed tokens,
// three random stages under different idle mixes and one stream ending.
// ----------------------------------------------------------------------------
module tb_top;
  import lztd_pkg::*;

  localparam int unsigned WIN_BITS    = 13;
  localparam int unsigned LEN_BITS    = 4;
  localparam int unsigned WIN_DEPTH   = 1 << WIN_BITS;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned STAGE_TOKENS = 80;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  typedef struct {
    logic                is_lit;
    logic [BYTE_W-1:0]   lit;
    logic [WIN_BITS-1:0] pos;
    logic [LEN_BITS-1:0] len_code;
  } token_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              data_ok;
    logic              last;
    logic              done;
  } beat_t;

  typedef enum {STOP_MARKER, STOP_LIMIT_MID, STOP_LIMIT_LOW} stop_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  wire                 in_ready;
  logic                in_is_literal = 1'b0;
  logic [BYTE_W-1:0]   in_literal_byte = '0;
  logic [WIN_BITS-1:0] in_match_position = '0;
  logic [LEN_BITS-1:0] in_match_length_code = '0;

  wire                 out_valid;
  logic                out_ready = 1'b0;
  wire  [BYTE_W-1:0]   out_byte;
  wire                 out_byte_valid;
  wire                 out_last_of_run;
  wire                 out_stream_done;

  logic                cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wr_data = '0;

  // window model of the decoder
  logic [BYTE_W-1:0]   win_model [WIN_DEPTH];
  logic [WIN_BITS-1:0] wr_ptr;
  logic [LIMIT_W-1:0]  emitted_cnt;
  logic [LIMIT_W-1:0]  limit_reg;
  bit                  halted;

  token_t token_backlog[$];
  beat_t  byte_beats_due[$];
  token_t cur_token;

  // bytes the queued tokens will emit, used to aim matches at written data
  logic [LIMIT_W-1:0] gen_bytes = '0;

  int unsigned tokens_queued = 0;
  int unsigned tokens_taken = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  stop_kind_t  stop_kind;

  always #6 clk = ~clk;

  lzss_token_decoder_unit #(
    .INDEX_BITS (WIN_BITS),
    .LENGTH_BITS(LEN_BITS)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_is_literal       (in_is_literal),
    .in_literal_byte     (in_literal_byte),
    .in_match_position   (in_match_position),
    .in_match_length_code(in_match_length_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_last_of_run     (out_last_of_run),
    .out_stream_done     (out_stream_done),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  // one byte leaves the decoder; returns 1 when the limit stops decoding
  function automatic bit append_byte(input logic [BYTE_W-1:0] b, input bit is_last);
    beat_t bt;
    emitted_cnt = emitted_cnt + LIMIT_W'(1);
    bt.data    = b;
    bt.data_ok = 1'b1;
    if (emitted_cnt >= limit_reg) begin
      bt.last = 1'b1;
      bt.done = 1'b1;
      byte_beats_due.push_back(bt);
      halted = 1'b1;
      return 1'b1;
    end
    bt.last = is_last;
    bt.done = 1'b0;
    byte_beats_due.push_back(bt);
    win_model[wr_ptr] = b;
    wr_ptr = wr_ptr + WIN_BITS'(1);
    return 1'b0;
  endfunction

  // expand one accepted token into the byte beats it must produce
  function automatic void expand_token(input token_t t);
    int unsigned copy_len;
    logic [WIN_BITS-1:0] rd_pos;
    beat_t bt;
    if (halted) return;
    if (t.is_lit) begin
      void'(append_byte(t.lit, 1'b1));
      return;
    end
    // position zero marks the end of the stream
    if (t.pos == '0) begin
      bt.data    = '0;
      bt.data_ok = 1'b0;
      bt.last    = 1'b1;
      bt.done    = 1'b1;
      byte_beats_due.push_back(bt);
      halted = 1'b1;
      return;
    end
    copy_len = int'(t.len_code) + MIN_COPY;
    rd_pos   = t.pos;
    // read after each write so overlapping copies see their own bytes
    for (int unsigned i = 0; i < copy_len; i++) begin
      if (append_byte(win_model[rd_pos], i + 1 == copy_len)) break;
      rd_pos = rd_pos + WIN_BITS'(1);
    end
  endfunction

  function automatic logic [WIN_BITS-1:0] gen_wp();
    logic [WIN_BITS-1:0] w;
    w = WIN_BITS'(gen_bytes + LIMIT_W'(1));
    return w;
  endfunction

  function automatic token_t lit_token(input logic [BYTE_W-1:0] b);
    token_t t;
    t.is_lit   = 1'b1;
    t.lit      = b;
    t.pos      = WIN_BITS'($urandom_range(0, WIN_DEPTH - 1));
    t.len_code = LEN_BITS'($urandom_range(0, (1 << LEN_BITS) - 1));
    return t;
  endfunction

  function automatic token_t match_token(input logic [WIN_BITS-1:0] p,
                                         input logic [LEN_BITS-1:0] c);
    token_t t;
    t.is_lit   = 1'b0;
    t.lit      = BYTE_W'($urandom_range(0, 255));
    t.pos      = p;
    t.len_code = c;
    return t;
  endfunction

  // mostly literals and matches into recent history, some matches anywhere
  function automatic token_t random_token();
    token_t t;
    int unsigned pick, span, back_off;
    t = lit_token(BYTE_W'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick >= 40) begin
      t.is_lit = 1'b0;
      if (pick < 85) begin
        span = (gen_bytes < 300) ? gen_bytes : 300;
        if ($urandom_range(0, 2) == 0)
          back_off = $urandom_range(1, (span < 4) ? span : 4);
        else
          back_off = $urandom_range(1, span);
        t.pos = gen_wp() - back_off[WIN_BITS-1:0];
      end else if (t.pos == '0) begin
        t.pos = WIN_BITS'(1);
      end
    end
    return t;
  endfunction

  function automatic void queue_token(input token_t t);
    token_backlog.push_back(t);
    tokens_queued++;
    if (t.is_lit)
      gen_bytes = gen_bytes + LIMIT_W'(1);
    else if (t.pos != '0)
      gen_bytes = gen_bytes + LIMIT_W'(t.len_code) + LIMIT_W'(MIN_COPY);
  endfunction

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    limit_reg    = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // all tokens taken, all beats seen, then let the sequencer settle
  task automatic wait_drained();
    while (tokens_taken != tokens_queued || byte_beats_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // token driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expand_token(cur_token);
        tokens_taken++;
      end
      if (!in_valid || in_ready) begin
        if (token_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_token = token_backlog.pop_front();
          in_valid             <= 1'b1;
          in_is_literal        <= cur_token.is_lit;
          in_literal_byte      <= cur_token.lit;
          in_match_position    <= cur_token.pos;
          in_match_length_code <= cur_token.len_code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // byte beat monitor
  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_checked++;
        if (byte_beats_due.size() == 0) begin
          $error("beat with nothing expected: out_byte %0h valid %0b last %0b done %0b",
                 out_byte, out_byte_valid, out_last_of_run, out_stream_done);
          mismatch_count++;
        end else begin
          want = byte_beats_due.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, out_byte);
            mismatch_count++;
          end
          if (out_byte_valid !== want.data_ok) begin
            $error("out_byte_valid: expected %0b, got %0b", want.data_ok, out_byte_valid);
            mismatch_count++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
            mismatch_count++;
          end
          if (out_stream_done !== want.done) begin
            $error("out_stream_done: expected %0b, got %0b", want.done, out_stream_done);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // model reset state
    foreach (win_model[i]) win_model[i] = '0;
    wr_ptr      = WIN_BITS'(1);
    emitted_cnt = '0;
    limit_reg   = LIMIT_MAX;
    halted      = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // stage one: sender and receiver both idle often
    send_idle_pct = 38;
    recv_idle_pct = 51;
    write_limit(LIMIT_MAX);

    // directed tokens: byte extremes, copies from start, overlap and wrap
    queue_token(lit_token(8'h00));
    queue_token(lit_token(8'hFF));
    queue_token(lit_token(8'hA5));
    queue_token(lit_token(8'h5A));
    queue_token('{1'b1, 8'h3C, '1, '1});
    queue_token('{1'b1, 8'hC3, '0, '0});
    queue_token(match_token(13'd1, 4'd0));
    queue_token(match_token(gen_wp() - WIN_BITS'(1), 4'd15));
    queue_token(match_token(gen_wp() - WIN_BITS'(3), 4'd5));
    queue_token(match_token(13'h1FFF, 4'd15));
    queue_token(match_token(13'd4096, 4'd3));
    queue_token(match_token(gen_wp(), 4'd2));
    queue_token(match_token(13'h1555, 4'hA));
    queue_token(match_token(13'h0AAA, 4'h5));
    queue_token(match_token(13'd2, 4'd15));

    repeat (STAGE_TOKENS) queue_token(random_token());
    wait_drained();

    // stage two: roles swapped
    send_idle_pct = 51;
    recv_idle_pct = 38;
    write_limit(LIMIT_W'($urandom_range(100000, LIMIT_MAX - 1)));
    repeat (STAGE_TOKENS) queue_token(random_token());
    wait_drained();

    // stage three: back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(LIMIT_W'($urandom_range(100000, LIMIT_MAX - 1)));
    repeat (STAGE_TOKENS) queue_token(random_token());
    wait_drained();

    // end the stream one of three ways, then tokens that must be dropped
    stop_kind = stop_kind_t'($urandom_range(0, 2));
    case (stop_kind)
      STOP_MARKER: begin
        queue_token(match_token('0, LEN_BITS'($urandom_range(0, 15))));
        wait_drained();
        write_limit(LIMIT_W'(1));
      end
      STOP_LIMIT_MID: begin
        write_limit(emitted_cnt + LIMIT_W'($urandom_range(1, 18)));
        queue_token(match_token(gen_wp() - WIN_BITS'($urandom_range(1, 8)), 4'd15));
      end
      default: begin
        // limit below the count: the next byte stops decoding
        write_limit(LIMIT_W'(1));
        queue_token(random_token());
      end
    endcase
    repeat (6) queue_token(random_token());
    queue_token(match_token('0, LEN_BITS'($urandom_range(0, 15))));
    wait_drained();

    $display("tokens taken: %0d, beats checked: %0d, bytes decoded: %0d",
             tokens_taken, beats_checked, emitted_cnt);
    $display("stream ended by %s under three idle mixes", stop_kind.name());
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
